// ----- rtl/amx_pkg.sv -----
// Shared types and constants for the affine matrix inverse block.
`default_nettype none
package amx_pkg;

    typedef logic [1:0] row_idx_t;

    localparam row_idx_t ROW_FIRST = 2'd0;
    localparam row_idx_t ROW_LAST  = 2'd2;

    localparam int LANES = 3;

    // cyclic neighbors used by the cofactor expansion
    localparam int NXT1 [0:2] = '{1, 2, 0};
    localparam int NXT2 [0:2] = '{2, 0, 1};

endpackage
`default_nettype wire

// ----- rtl/amx_if.sv -----
// Valid/ready channel interfaces for the matrix input and the row results.
`default_nettype none
interface amx_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_r0c0;
    logic signed [W-1:0] in_r0c1;
    logic signed [W-1:0] in_r0c2;
    logic signed [W-1:0] in_r0c3;
    logic signed [W-1:0] in_r1c0;
    logic signed [W-1:0] in_r1c1;
    logic signed [W-1:0] in_r1c2;
    logic signed [W-1:0] in_r1c3;
    logic signed [W-1:0] in_r2c0;
    logic signed [W-1:0] in_r2c1;
    logic signed [W-1:0] in_r2c2;
    logic signed [W-1:0] in_r2c3;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3, in_r1c0, in_r1c1, in_r1c2,
               in_r1c3, in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3, in_r1c0, in_r1c1, in_r1c2,
               in_r1c3, in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        output ready
    );
endinterface

interface amx_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    amx_pkg::row_idx_t   out_row;
    logic signed [W-1:0] out_c0;
    logic signed [W-1:0] out_c1;
    logic signed [W-1:0] out_c2;
    logic signed [W-1:0] out_c3;
    logic                is_singular;
    logic                is_last;

    modport source (
        output valid, out_row, out_c0, out_c1, out_c2, out_c3, is_singular, is_last,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_c0, out_c1, out_c2, out_c3, is_singular, is_last,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/amx_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`default_nettype none
module amx_div #(
    parameter int QW   = 32,
    parameter int NW   = 97,
    parameter int DW   = 99,
    parameter int TAGW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [NW-1:0]   in_num [0:amx_pkg::LANES-1],
    input  wire logic [DW-1:0]   in_den,
    input  wire logic [TAGW-1:0] in_tag,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [QW-1:0]        out_q   [0:amx_pkg::LANES-1],
    output logic                 out_rnd [0:amx_pkg::LANES-1],
    output logic                 out_ovf [0:amx_pkg::LANES-1],
    output logic [TAGW-1:0]      out_tag
);
    localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;
    localparam int NS = QW + 2;
    localparam int L  = amx_pkg::LANES;

    logic            v_reg   [0:NS-1];
    logic            take    [0:NS];
    logic [RW-1:0]   r_reg   [0:NS-1][0:L-1];
    logic [QW-1:0]   q_reg   [0:NS-1][0:L-1];
    logic            ovf_reg [0:NS-1][0:L-1];
    logic            rnd_reg [0:L-1];
    logic [DW-1:0]   den_reg [0:NS-1];
    logic [TAGW-1:0] tag_reg [0:NS-1];

    assign take[NS]  = out_ready;
    assign in_ready  = take[0];
    assign out_valid = v_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            out_q[l]   = q_reg[NS-1][l];
            out_rnd[l] = rnd_reg[l];
            out_ovf[l] = ovf_reg[NS-1][l];
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        assign take[s] = !v_reg[s] || take[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (take[s])
            begin
                v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s - 1];
            end
        end

        if (s == 0)
        begin : g_pre
            // flag quotients that cannot fit before the bit steps start
            always_ff @(posedge clk)
            begin
                if (take[s])
                begin
                    den_reg[s] <= in_den;
                    tag_reg[s] <= in_tag;
                    for (int l = 0; l < L; l++)
                    begin
                        r_reg[s][l]   <= RW'(in_num[l]);
                        q_reg[s][l]   <= '0;
                        ovf_reg[s][l] <= RW'(in_num[l]) >= (RW'(in_den) << QW);
                    end
                end
            end
        end
        else if (s <= QW)
        begin : g_step
            localparam int K = QW - s;
            logic [RW-1:0] dk;
            assign dk = RW'(den_reg[s-1]) << K;

            always_ff @(posedge clk)
            begin
                if (take[s])
                begin
                    den_reg[s] <= den_reg[s-1];
                    tag_reg[s] <= tag_reg[s-1];
                    for (int l = 0; l < L; l++)
                    begin
                        ovf_reg[s][l] <= ovf_reg[s-1][l];
                        if (r_reg[s-1][l] >= dk)
                        begin
                            r_reg[s][l]    <= r_reg[s-1][l] - dk;
                            q_reg[s][l]    <= q_reg[s-1][l];
                            q_reg[s][l][K] <= 1'b1;
                        end
                        else
                        begin
                            r_reg[s][l] <= r_reg[s-1][l];
                            q_reg[s][l] <= q_reg[s-1][l];
                        end
                    end
                end
            end
        end
        else
        begin : g_round
            // round half away: remainder at least half the divisor
            always_ff @(posedge clk)
            begin
                if (take[s])
                begin
                    den_reg[s] <= den_reg[s-1];
                    tag_reg[s] <= tag_reg[s-1];
                    for (int l = 0; l < L; l++)
                    begin
                        r_reg[s][l]   <= r_reg[s-1][l];
                        q_reg[s][l]   <= q_reg[s-1][l];
                        ovf_reg[s][l] <= ovf_reg[s-1][l];
                        rnd_reg[l]    <= {r_reg[s-1][l], 1'b0} >= (RW + 1)'(den_reg[s-1]);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/affine_matrix_inverse_top.sv -----
// Affine 3x4 matrix inverse: cofactors, determinant, exact rounded division, translation.
// Path: a matrix beat passes stages S1 to S6, the three-lane divider and P0 to P3; rows 1
// and 2 follow row 0 on the next cycles when the result side keeps ready high.
// Throughput: one row beat every cycle while the result side keeps ready high; the row
// sequencer takes a new matrix for the divider only once it has issued its last row.
// Reset clears every valid bit and the row counter; payload registers are not reset.
`default_nettype none
module affine_matrix_inverse_top #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    amx_in_if.sink    matrix,
    amx_out_if.source result
);
    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = 2 * W + 1;     // adjugate entry
    localparam int DETW = 3 * W + 3;     // determinant
    localparam int NW   = AW + 2 * F;    // scaled numerator magnitude
    localparam int MW   = 2 * W + 2;     // translation accumulator
    localparam int L    = amx_pkg::LANES;

    localparam logic [W-1:0] EMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] EMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [MW:0]  HALF = (MW + 1)'(1) << (W - 1);
    localparam logic [MW:0]  PLIM = HALF - (MW + 1)'(1);
    localparam logic [MW:0]  RBIT = (MW + 1)'(1) << (F - 1);

    typedef struct packed {
        amx_pkg::row_idx_t   row;
        logic                last;
        logic                sing;
        logic [L-1:0]        neg;
        logic [L-1:0][W-1:0] t;
    } tag_t;

    localparam int TAGW = $bits(tag_t);

    // ---------------- input capture ----------------
    logic signed [W-1:0] m_in [0:2][0:3];
    assign m_in[0][0] = matrix.in_r0c0;
    assign m_in[0][1] = matrix.in_r0c1;
    assign m_in[0][2] = matrix.in_r0c2;
    assign m_in[0][3] = matrix.in_r0c3;
    assign m_in[1][0] = matrix.in_r1c0;
    assign m_in[1][1] = matrix.in_r1c1;
    assign m_in[1][2] = matrix.in_r1c2;
    assign m_in[1][3] = matrix.in_r1c3;
    assign m_in[2][0] = matrix.in_r2c0;
    assign m_in[2][1] = matrix.in_r2c1;
    assign m_in[2][2] = matrix.in_r2c2;
    assign m_in[2][3] = matrix.in_r2c3;

    // stage handshake: a stage takes a beat when empty or when its beat moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic take1, take2, take3, take4, take5, take6;
    logic div_in_ready;
    amx_pkg::row_idx_t row6_reg;

    assign take1 = !v1_reg || take2;
    assign take2 = !v2_reg || take3;
    assign take3 = !v3_reg || take4;
    assign take4 = !v4_reg || take5;
    assign take5 = !v5_reg || take6;
    assign take6 = !v6_reg || (div_in_ready && row6_reg == amx_pkg::ROW_LAST);

    assign matrix.ready = take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (take1) v1_reg <= matrix.valid;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
            if (take4) v4_reg <= v3_reg;
            if (take5) v5_reg <= v4_reg;
        end
    end

    // S1: register the matrix beat
    logic signed [W-1:0] m1_reg [0:2][0:3];
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            m1_reg <= m_in;
        end
    end

    // S2: two 2x2 minor products per cofactor
    logic signed [2*W-1:0] pa2_reg [0:2][0:2];
    logic signed [2*W-1:0] pb2_reg [0:2][0:2];
    logic signed [W-1:0]   r02_reg [0:2];
    logic signed [W-1:0]   t2_reg  [0:2];
    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r02_reg[i] <= m1_reg[0][i];
                t2_reg[i]  <= m1_reg[i][3];
                for (int j = 0; j < 3; j++)
                begin
                    pa2_reg[i][j] <= m1_reg[amx_pkg::NXT1[j]][amx_pkg::NXT1[i]]
                                   * m1_reg[amx_pkg::NXT2[j]][amx_pkg::NXT2[i]];
                    pb2_reg[i][j] <= m1_reg[amx_pkg::NXT1[j]][amx_pkg::NXT2[i]]
                                   * m1_reg[amx_pkg::NXT2[j]][amx_pkg::NXT1[i]];
                end
            end
        end
    end

    // S3: adjugate entries
    logic signed [AW-1:0] adj3_reg [0:2][0:2];
    logic signed [W-1:0]  r03_reg  [0:2];
    logic signed [W-1:0]  t3_reg   [0:2];
    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            r03_reg <= r02_reg;
            t3_reg  <= t2_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    adj3_reg[i][j] <= AW'(pa2_reg[i][j]) - AW'(pb2_reg[i][j]);
                end
            end
        end
    end

    // S4: determinant partial products, adjugate split into low and high halves
    logic signed [2*W:0]  dlo4_reg [0:2];
    logic signed [2*W:0]  dhi4_reg [0:2];
    logic signed [AW-1:0] adj4_reg [0:2][0:2];
    logic signed [W-1:0]  t4_reg   [0:2];
    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            adj4_reg <= adj3_reg;
            t4_reg   <= t3_reg;
            for (int j = 0; j < 3; j++)
            begin
                dlo4_reg[j] <= r03_reg[j] * $signed({1'b0, adj3_reg[j][0][W-1:0]});
                dhi4_reg[j] <= r03_reg[j] * $signed(adj3_reg[j][0][AW-1:W]);
            end
        end
    end

    // S5: determinant sum
    logic signed [DETW-1:0] det_sum;
    always_comb
    begin
        det_sum = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_sum = det_sum + (DETW'(dhi4_reg[j]) <<< W) + DETW'(dlo4_reg[j]);
        end
    end

    logic signed [DETW-1:0] det5_reg;
    logic signed [AW-1:0]   adj5_reg [0:2][0:2];
    logic signed [W-1:0]    t5_reg   [0:2];
    always_ff @(posedge clk)
    begin
        if (take5)
        begin
            det5_reg <= det_sum;
            adj5_reg <= adj4_reg;
            t5_reg   <= t4_reg;
        end
    end

    // S6: row sequencer, hold the matrix and issue one row per divider beat
    logic signed [DETW-1:0] det6_reg;
    logic signed [AW-1:0]   adj6_reg [0:2][0:2];
    logic signed [W-1:0]    t6_reg   [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg   <= 1'b0;
            row6_reg <= amx_pkg::ROW_FIRST;
        end
        else if (take6)
        begin
            v6_reg   <= v5_reg;
            row6_reg <= amx_pkg::ROW_FIRST;
        end
        else if (div_in_ready)
        begin
            row6_reg <= row6_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take6)
        begin
            det6_reg <= det5_reg;
            adj6_reg <= adj5_reg;
            t6_reg   <= t5_reg;
        end
    end

    // divider operands: magnitudes, with the signs riding along in the tag
    logic [NW-1:0]   div_num [0:L-1];
    logic [DETW-1:0] div_den;
    tag_t            div_tag;
    logic [AW-1:0]   adj_mag;

    always_comb
    begin
        adj_mag   = '0;
        div_den   = det6_reg[DETW-1] ? DETW'(-det6_reg) : DETW'(det6_reg);
        div_tag.row  = row6_reg;
        div_tag.last = (row6_reg == amx_pkg::ROW_LAST);
        div_tag.sing = (det6_reg == '0);
        for (int j = 0; j < L; j++)
        begin
            adj_mag = adj6_reg[row6_reg][j][AW-1] ? AW'(-adj6_reg[row6_reg][j])
                                                   : AW'(adj6_reg[row6_reg][j]);
            div_num[j]     = NW'(adj_mag) << (2 * F);
            div_tag.neg[j] = adj6_reg[row6_reg][j][AW-1] ^ det6_reg[DETW-1];
            div_tag.t[j]   = t6_reg[j];
        end
    end

    logic            div_out_valid;
    logic            take_p0;
    logic [W-1:0]    div_q   [0:L-1];
    logic            div_rnd [0:L-1];
    logic            div_ovf [0:L-1];
    logic [TAGW-1:0] div_out_tag;

    amx_div #(
        .QW   (W),
        .NW   (NW),
        .DW   (DETW),
        .TAGW (TAGW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_ready  (div_in_ready),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_tag    (div_tag),
        .out_valid (div_out_valid),
        .out_ready (take_p0),
        .out_q     (div_q),
        .out_rnd   (div_rnd),
        .out_ovf   (div_ovf),
        .out_tag   (div_out_tag)
    );

    // ---------------- back end ----------------
    logic vp0_reg, vp1_reg, vp2_reg, vp3_reg;
    logic take_p1, take_p2, take_p3;

    assign take_p0 = !vp0_reg || take_p1;
    assign take_p1 = !vp1_reg || take_p2;
    assign take_p2 = !vp2_reg || take_p3;
    assign take_p3 = !vp3_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp0_reg <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
        end
        else
        begin
            if (take_p0) vp0_reg <= div_out_valid;
            if (take_p1) vp1_reg <= vp0_reg;
            if (take_p2) vp2_reg <= vp1_reg;
            if (take_p3) vp3_reg <= vp2_reg;
        end
    end

    // P0: round the quotient, apply the sign, saturate, zero a singular matrix
    tag_t         dtag;
    logic [W:0]   qr;
    logic [W-1:0] e_next [0:L-1];

    assign dtag = tag_t'(div_out_tag);

    always_comb
    begin
        qr = '0;
        for (int j = 0; j < L; j++)
        begin
            qr = {1'b0, div_q[j]} + (W + 1)'(div_rnd[j]);
            if (dtag.sing)
            begin
                e_next[j] = '0;
            end
            else if (!dtag.neg[j])
            begin
                e_next[j] = (div_ovf[j] || qr[W] || qr[W-1]) ? EMAX : qr[W-1:0];
            end
            else
            begin
                e_next[j] = (div_ovf[j] || qr > (W + 1)'(HALF)) ? EMIN : W'(-qr);
            end
        end
    end

    logic signed [W-1:0] e0_reg [0:L-1];
    tag_t                tag0_reg;
    always_ff @(posedge clk)
    begin
        if (take_p0)
        begin
            tag0_reg <= dtag;
            for (int j = 0; j < L; j++)
            begin
                e0_reg[j] <= $signed(e_next[j]);
            end
        end
    end

    // P1: saturated elements times old translation
    logic signed [2*W-1:0] pr1_reg [0:L-1];
    logic signed [W-1:0]   e1_reg  [0:L-1];
    tag_t                  tag1_reg;
    always_ff @(posedge clk)
    begin
        if (take_p1)
        begin
            tag1_reg <= tag0_reg;
            e1_reg   <= e0_reg;
            for (int j = 0; j < L; j++)
            begin
                pr1_reg[j] <= e0_reg[j] * $signed(tag0_reg.t[j]);
            end
        end
    end

    // P2: dot product
    logic signed [MW-1:0] acc2_reg;
    logic signed [W-1:0]  e2_reg [0:L-1];
    tag_t                 tag2_reg;
    always_ff @(posedge clk)
    begin
        if (take_p2)
        begin
            tag2_reg <= tag1_reg;
            e2_reg   <= e1_reg;
            acc2_reg <= MW'(pr1_reg[0]) + MW'(pr1_reg[1]) + MW'(pr1_reg[2]);
        end
    end

    // P3: drop the fraction with round half away, negate, saturate, zero a singular matrix
    logic [MW-1:0] acc_mag;
    logic [MW:0]   acc_rnd;
    logic [W-1:0]  tr_next;

    always_comb
    begin
        acc_mag = acc2_reg[MW-1] ? MW'(-acc2_reg) : MW'(acc2_reg);
        acc_rnd = (({1'b0, acc_mag} + RBIT) >> F);
        if (tag2_reg.sing)
        begin
            tr_next = '0;
        end
        else if (acc2_reg[MW-1])
        begin
            tr_next = (acc_rnd > PLIM) ? EMAX : acc_rnd[W-1:0];
        end
        else
        begin
            tr_next = (acc_rnd > HALF) ? EMIN : W'(-acc_rnd[W-1:0]);
        end
    end

    amx_pkg::row_idx_t   row3_reg;
    logic signed [W-1:0] c3_reg [0:3];
    logic                sing3_reg;
    logic                last3_reg;
    always_ff @(posedge clk)
    begin
        if (take_p3)
        begin
            row3_reg  <= tag2_reg.row;
            sing3_reg <= tag2_reg.sing;
            last3_reg <= tag2_reg.last;
            c3_reg[0] <= e2_reg[0];
            c3_reg[1] <= e2_reg[1];
            c3_reg[2] <= e2_reg[2];
            c3_reg[3] <= $signed(tr_next);
        end
    end

    assign result.valid       = vp3_reg;
    assign result.out_row     = row3_reg;
    assign result.out_c0      = c3_reg[0];
    assign result.out_c1      = c3_reg[1];
    assign result.out_c2      = c3_reg[2];
    assign result.out_c3      = c3_reg[3];
    assign result.is_singular = sing3_reg;
    assign result.is_last     = last3_reg;
endmodule
`default_nettype wire

// ----- rtl/amx_checker.sv -----
// Port-level checks on the result stream of the affine matrix inverse, with its bind.
`default_nettype none
module amx_checker #(
    parameter int W = 32
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire amx_pkg::row_idx_t out_row,
    input wire logic [W-1:0]      out_c0,
    input wire logic [W-1:0]      out_c1,
    input wire logic [W-1:0]      out_c2,
    input wire logic [W-1:0]      out_c3,
    input wire logic              is_singular,
    input wire logic              is_last
);
    amx_pkg::row_idx_t exp_row_reg;
    logic              sing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= amx_pkg::ROW_FIRST;
            sing_reg    <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            exp_row_reg <= is_last ? amx_pkg::ROW_FIRST : out_row + 2'd1;
            sing_reg    <= is_singular;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped under stall");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_row == exp_row_reg)
        else $error("rows out of order");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_last == (out_row == amx_pkg::ROW_LAST))
        else $error("last mark not on final row");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_singular |->
            out_c0 == '0 && out_c1 == '0 && out_c2 == '0 && out_c3 == '0)
        else $error("singular row carries nonzero elements");

    a_sing_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_row != amx_pkg::ROW_FIRST |-> is_singular == sing_reg)
        else $error("singular flag changed within one matrix");
endmodule

bind affine_matrix_inverse_top amx_checker #(.W(ELEM_WIDTH)) u_amx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_row     (result.out_row),
    .out_c0      (result.out_c0),
    .out_c1      (result.out_c1),
    .out_c2      (result.out_c2),
    .out_c3      (result.out_c3),
    .is_singular (result.is_singular),
    .is_last     (result.is_last)
);
`default_nettype wire
